FILE: design/tlvp_pkg.sv
// Shared types and constants for the TLV image parser.
package tlvp_pkg;

  localparam int unsigned HEADER_BYTES = 5;
  localparam int unsigned SIZE_BITS    = 21;
  localparam int unsigned CFG_W        = 21;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TYPE    = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_TAIL    = 3'd4,
    PH_STOPPED = 3'd5,
    PH_END     = 3'd6
  } phase_t;

  localparam logic [2:0] ROLE_HEADER  = 3'd0;
  localparam logic [2:0] ROLE_TYPE    = 3'd1;
  localparam logic [2:0] ROLE_LENGTH  = 3'd2;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd3;
  localparam logic [2:0] ROLE_IGNORED = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SMALL  = 2'd1;
  localparam logic [1:0] ST_MAGIC  = 2'd2;
  localparam logic [1:0] ST_BADLEN = 2'd3;

  localparam logic [1:0] CLS_CA    = 2'd0;
  localparam logic [1:0] CLS_CERT  = 2'd1;
  localparam logic [1:0] CLS_KEY   = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  localparam logic [1:0] CFG_IMAGE_SIZE = 2'd0;
  localparam logic [1:0] CFG_CODE_CA    = 2'd1;
  localparam logic [1:0] CFG_CODE_CERT  = 2'd2;
  localparam logic [1:0] CFG_CODE_KEY   = 2'd3;

  localparam logic [SIZE_BITS-1:0] RST_IMAGE_SIZE = '0;
  localparam logic [7:0] RST_CODE_CA   = 8'd1;
  localparam logic [7:0] RST_CODE_CERT = 8'd2;
  localparam logic [7:0] RST_CODE_KEY  = 8'd3;

  typedef struct packed {
    logic [SIZE_BITS-1:0] image_size;
    logic [7:0]           code_ca;
    logic [7:0]           code_cert;
    logic [7:0]           code_key;
  } cfg_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] byte_role;
    logic [1:0] record_class;
    logic       record_end;
    logic [1:0] parse_status;
    logic       image_end;
  } res_t;

  // Header magic, indexed by byte position 0..3.
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'h53;  // 'S'
      2'd1:    m = 8'h50;  // 'P'
      2'd2:    m = 8'h43;  // 'C'
      2'd3:    m = 8'h46;  // 'F'
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

FILE: design/tlvp_core.sv
// Parser state and per-byte decode: phase tracking, length capture, payload tagging.
module tlvp_core #(
  parameter int unsigned POSITION_BITS = 20
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            start_of_image,
  input  tlvp_pkg::cfg_t  cfg,
  output tlvp_pkg::res_t  res
);
  import tlvp_pkg::*;

  localparam int unsigned PB = POSITION_BITS;
  localparam int unsigned SW = ((PB > SIZE_BITS) ? PB : SIZE_BITS) + 1;
  localparam int unsigned CW = ((PB > 32) ? PB : 32) + 2;

  phase_t          phase_r, phase_nxt, phase_c, phase0;
  logic [PB-1:0]   pos_r, pos_nxt, pos_c;
  logic [31:0]     acc_r, acc_nxt, acc_c;
  logic [7:0]      type_r, type_nxt, type_c;
  logic [PB-1:0]   left_r, left_nxt, left_c, left_dec;
  logic [1:0]      st_r, st_nxt, st_c;

  logic [SW-1:0]   size_ext, size_cap, size_eff, pos_s;
  logic            live, iend, too_small, magic_bad, tail, len_last, len_bad;
  logic [1:0]      k;
  logic [31:0]     len_full;
  logic [2:0]      role;
  logic [1:0]      cls;
  logic            rend;

  function automatic logic [1:0] class_of(input logic [7:0] t, input cfg_t c);
    logic [1:0] r;
    if (t == c.code_ca)        r = CLS_CA;
    else if (t == c.code_cert) r = CLS_CERT;
    else if (t == c.code_key)  r = CLS_KEY;
    else                       r = CLS_OTHER;
    return r;
  endfunction

  // Start flag acts as a restart ahead of this byte.
  always_comb begin
    pos_c   = start_of_image ? '0 : pos_r;
    phase_c = start_of_image ? PH_HEADER : phase_r;
    acc_c   = start_of_image ? '0 : acc_r;
    type_c  = start_of_image ? '0 : type_r;
    left_c  = start_of_image ? '0 : left_r;
    st_c    = start_of_image ? ST_OK : st_r;
  end

  always_comb begin
    size_ext  = SW'(cfg.image_size);
    size_cap  = SW'(1) << PB;
    size_eff  = (size_ext > size_cap) ? size_cap : size_ext;
    pos_s     = SW'(pos_c);
    live      = (phase_c != PH_END) && (pos_s < size_eff);
    phase0    = live ? phase_c : PH_END;
    iend      = live && ((pos_s + SW'(1)) == size_eff);
    too_small = size_eff < SW'(HEADER_BYTES);
    magic_bad = data_byte != magic_byte(pos_c[1:0]);
    tail      = (pos_s + SW'(HEADER_BYTES)) > size_eff;
    k         = left_c[1:0];
    len_last  = k == 2'd3;
    len_full  = acc_c | {data_byte, 24'h0};
    len_bad   = (len_full == 32'h0) ||
                ((CW'(pos_c) + CW'(1) + CW'(len_full)) > CW'(size_eff));
    left_dec  = (left_c != '0) ? left_c - PB'(1) : left_c;
  end

  // Next phase.
  always_comb begin
    phase_nxt = phase0;
    if (live) begin
      case (phase_c)
        PH_HEADER: begin
          if (too_small) phase_nxt = PH_STOPPED;
          else if (pos_c < PB'(4)) begin
            if (magic_bad) phase_nxt = PH_STOPPED;
          end else phase_nxt = PH_TYPE;
        end
        PH_TYPE:    phase_nxt = tail ? PH_TAIL : PH_LEN;
        PH_LEN: begin
          if (len_last) phase_nxt = len_bad ? PH_STOPPED : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (left_dec == '0) phase_nxt = PH_TYPE;
        end
        default:    phase_nxt = phase0;
      endcase
      if (iend) phase_nxt = PH_END;
    end
  end

  // Per-byte outputs and datapath state.
  always_comb begin
    role     = ROLE_IGNORED;
    cls      = CLS_CA;
    rend     = 1'b0;
    st_nxt   = st_c;
    acc_nxt  = acc_c;
    type_nxt = type_c;
    left_nxt = left_c;
    pos_nxt  = pos_c;
    if (live) begin
      pos_nxt = pos_c + PB'(1);
      case (phase_c)
        PH_HEADER: begin
          if (too_small) st_nxt = ST_SMALL;
          else begin
            role = ROLE_HEADER;
            if ((pos_c < PB'(4)) && magic_bad) st_nxt = ST_MAGIC;
          end
        end
        PH_TYPE: begin
          if (!tail) begin
            role     = ROLE_TYPE;
            type_nxt = data_byte;
            acc_nxt  = '0;
            left_nxt = '0;
          end
        end
        PH_LEN: begin
          role    = ROLE_LENGTH;
          acc_nxt = acc_c | (32'(data_byte) << {k, 3'b000});
          if (len_last) begin
            if (len_bad) begin
              st_nxt   = ST_BADLEN;
              left_nxt = '0;
            end else begin
              // Length fits below the image size, so it fits the position width.
              left_nxt = len_full[PB-1:0];
            end
          end else begin
            left_nxt = PB'(k) + PB'(1);
          end
        end
        PH_PAYLOAD: begin
          role     = ROLE_PAYLOAD;
          cls      = class_of(type_c, cfg);
          left_nxt = left_dec;
          rend     = left_dec == '0;
        end
        default: role = ROLE_IGNORED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      acc_r   <= '0;
      type_r  <= '0;
      left_r  <= '0;
      st_r    <= ST_OK;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      acc_r   <= acc_nxt;
      type_r  <= type_nxt;
      left_r  <= left_nxt;
      st_r    <= st_nxt;
    end
  end

  always_comb begin
    res.byte_out     = data_byte;
    res.byte_role    = role;
    res.record_class = cls;
    res.record_end   = rend;
    res.parse_status = st_nxt;
    res.image_end    = iend;
  end

endmodule

FILE: design/tlv_image_parser.sv
// Top level of the TLV image parser: config registers, parser core, output skid stage.
//
// Bytes of an image enter on the in_ stream, one per transaction; in_tuser
// carries the start flag that restarts parsing on the first byte of an image.
// Every accepted byte yields exactly one result transaction on the out_
// stream: the byte itself, its role, the record class, record end, the
// parse status after the byte and, on out_tlast, the last byte of the image.
// Each result is registered (in the output or skid register) before out_tvalid. Throughput is
// one byte per cycle while in_tready stays high; the parser state updates in the accepting
// cycle, so consecutive bytes flow without gaps.
// When the receiver stalls, one further byte is taken into a skid register;
// in_tready then drops until the receiver takes the held result.
// The user writes configuration through cfg_wr_en/cfg_index/cfg_wdata only while
// the stream is idle; the block does not enforce this. Reset clears the parser to the
// header phase, the image size to zero, the type codes to 1, 2 and 3, and empties the output.
module tlv_image_parser #(
  parameter int unsigned POSITION_BITS = 20
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] data_byte
  input  logic                       in_tuser,   // [0] start_of_image
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,  // [7:0] byte_out
  output logic [7:0]                 out_tuser,  // [2:0] byte_role, [4:3] record_class,
                                                 // [5] record_end, [7:6] parse_status
  output logic                       out_tlast,  // image_end
  input  logic                       cfg_wr_en,
  input  logic [1:0]                 cfg_index,
  input  logic [tlvp_pkg::CFG_W-1:0] cfg_wdata
);
  import tlvp_pkg::*;

  cfg_t cfg_r;
  res_t res;
  res_t out_r, skid_r;
  logic out_v_r, skid_v_r;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_size <= RST_IMAGE_SIZE;
      cfg_r.code_ca    <= RST_CODE_CA;
      cfg_r.code_cert  <= RST_CODE_CERT;
      cfg_r.code_key   <= RST_CODE_KEY;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IMAGE_SIZE: cfg_r.image_size <= cfg_wdata[SIZE_BITS-1:0];
        CFG_CODE_CA:    cfg_r.code_ca    <= cfg_wdata[7:0];
        CFG_CODE_CERT:  cfg_r.code_cert  <= cfg_wdata[7:0];
        CFG_CODE_KEY:   cfg_r.code_key   <= cfg_wdata[7:0];
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  assign in_tready = !skid_v_r;
  assign accept    = in_tvalid && in_tready;

  tlvp_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .data_byte      (in_tdata),
    .start_of_image (in_tuser),
    .cfg            (cfg_r),
    .res            (res)
  );

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= accept;
      end
    end else if (accept) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      if (skid_v_r) out_r <= skid_r;
      else if (accept) out_r <= res;
    end else if (accept) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r.byte_out;
  assign out_tuser  = {out_r.parse_status, out_r.record_end, out_r.record_class,
                       out_r.byte_role};
  assign out_tlast  = out_r.image_end;

endmodule
